// File: rtl/jjjc_pkg.sv
// jjjc_pkg: shared types, codes and constants of the joystick joint jog controller
// no dependencies; imported by every module of the block

package jjjc_pkg;

  // sizes
  localparam int NUM_JOINTS = 6;
  localparam int JOINT_W    = $clog2(NUM_JOINTS);
  localparam int ANGLE_BITS = 20;
  localparam int AXIS_W     = 16;
  localparam int AXIS_FRAC  = 15;
  localparam int DZ_W       = 15;
  localparam int STEP_W     = 16;
  localparam int NUM_AXES   = 3;
  localparam int PROD_W     = AXIS_W + STEP_W + 1;
  localparam int DELTA_W    = PROD_W - AXIS_FRAC;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // axis slots inside the delta stage
  localparam int AXIS_LX = 0;
  localparam int AXIS_RX = 1;
  localparam int AXIS_LY = 2;

  // clamp used when a joint has no limits: +-pi, cut to the angle range
  localparam longint PI_FIX    = 205887;
  localparam longint ANGLE_MAX = (longint'(1) <<< (ANGLE_BITS - 1)) - 1;
  localparam longint CLAMP_PI  = (PI_FIX > ANGLE_MAX) ? ANGLE_MAX : PI_FIX;

  // register defaults
  localparam logic [DZ_W-1:0]   DEADZONE_RESET = DZ_W'(1638);
  localparam logic [STEP_W-1:0] JOG_STEP_RESET = STEP_W'(197);

  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [AXIS_W-1:0]     axis_t;
  typedef logic signed [DELTA_W-1:0]    delta_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ANGLE = 2'd1,
    CMD_LIMIT = 2'd2,
    CMD_SPARE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SW_LEFT    = 2'd0,
    SW_MIDDLE  = 2'd1,
    SW_RIGHT   = 2'd2,
    SW_UNKNOWN = 2'd3
  } switch_t;

  typedef enum logic [2:0] {
    MODE_NONE    = 3'd0,
    MODE_POS     = 3'd1,
    MODE_ORIENT  = 3'd2,
    MODE_GRIPPER = 3'd3,
    MODE_CUSTOM  = 3'd4
  } mode_t;

  // input item
  typedef struct packed {
    cmd_t               cmd;
    switch_t            switch_pos;
    logic               button_one;
    logic               button_two;
    axis_t              left_x;
    axis_t              left_y;
    axis_t              right_x;
    logic [JOINT_W-1:0] joint_sel;
    angle_t             value_a;
    angle_t             value_b;
    logic               value_valid;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [JOINT_W-1:0] out_joint;
    angle_t             target_angle;
    logic               enabled;
    mode_t              mode;
    logic               last_joint;
  } out_item_t;

  // configuration registers
  typedef struct packed {
    logic [DZ_W-1:0]   deadzone;
    logic [STEP_W-1:0] jog_step;
  } cfg_t;

  // item plus per-axis jog deltas and deadzone decisions
  typedef struct packed {
    in_item_t                  item;
    delta_t [NUM_AXES-1:0]     delta;
    logic   [NUM_AXES-1:0]     move;
  } mid_t;

  // one tick's worth of results
  typedef struct packed {
    angle_t [NUM_JOINTS-1:0] targets;
    logic                    enabled;
    mode_t                   mode;
  } burst_t;

endpackage

// File: rtl/jjjc_regs.sv
// jjjc_regs: APB-style configuration registers (deadzone, jog step)
// depends on jjjc_pkg

module jjjc_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [jjjc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [jjjc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [jjjc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output jjjc_pkg::cfg_t                 cfg
);
  import jjjc_pkg::*;

  localparam logic REG_DEADZONE = 1'b0;
  localparam logic REG_JOG_STEP = 1'b1;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadzone <= DEADZONE_RESET;
      cfg.jog_step <= JOG_STEP_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_DEADZONE: cfg.deadzone <= pwdata[DZ_W-1:0];
        REG_JOG_STEP: cfg.jog_step <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (paddr[2])
      REG_DEADZONE: prdata = CFG_DATA_W'(cfg.deadzone);
      REG_JOG_STEP: prdata = CFG_DATA_W'(cfg.jog_step);
      default:      prdata = '0;
    endcase
  end

endmodule

// File: rtl/jjjc_delta.sv
// jjjc_delta: input register stage; forms (jog_step*axis)>>15 and the deadzone test per axis
// depends on jjjc_pkg

module jjjc_delta (
  input  logic               clk,
  input  logic               rst,
  input  jjjc_pkg::cfg_t     cfg,
  input  logic               item_valid,
  output logic               item_stall,
  input  jjjc_pkg::in_item_t item,
  output logic               mid_valid,
  input  logic               mid_ready,
  output jjjc_pkg::mid_t     mid
);
  import jjjc_pkg::*;

  axis_t                     axis_in [NUM_AXES];
  logic signed [PROD_W-1:0]  prod    [NUM_AXES];
  logic [AXIS_W:0]           ax_ext  [NUM_AXES];
  logic [AXIS_W:0]           mag     [NUM_AXES];
  mid_t                      mid_next;

  assign axis_in[AXIS_LX] = item.left_x;
  assign axis_in[AXIS_RX] = item.right_x;
  assign axis_in[AXIS_LY] = item.left_y;

  // per-axis scaled step and deadzone decision
  always_comb begin
    mid_next.item = item;
    for (int a = 0; a < NUM_AXES; a++) begin
      prod[a]   = $signed({1'b0, cfg.jog_step}) * axis_in[a];
      mid_next.delta[a] = prod[a][PROD_W-1:AXIS_FRAC];
      ax_ext[a] = {axis_in[a][AXIS_W-1], axis_in[a]};
      mag[a]    = ax_ext[a][AXIS_W] ? (~ax_ext[a] + 1'b1) : ax_ext[a];
      mid_next.move[a] = mag[a] > (AXIS_W + 1)'(cfg.deadzone);
    end
  end

  assign item_stall = mid_valid && !mid_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (!item_stall) begin
      mid_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      mid <= mid_next;
    end
  end

endmodule

// File: rtl/jjjc_core.sv
// jjjc_core: joint state, mode logic, jog add and clamp; hands a tick's targets to the emitter
// depends on jjjc_pkg

module jjjc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             mid_valid,
  output logic             mid_ready,
  input  jjjc_pkg::mid_t   mid,
  input  logic             emit_ready,
  output logic             burst_load,
  output jjjc_pkg::burst_t burst
);
  import jjjc_pkg::*;

  localparam int SUM_W = ((ANGLE_BITS > DELTA_W) ? ANGLE_BITS : DELTA_W) + 1;

  // which stick axis drives each joint, its sign, and the mode that jogs it
  localparam int    JOINT_AXIS [NUM_JOINTS] = '{AXIS_LY, AXIS_RX, AXIS_LX,
                                                AXIS_LY, AXIS_RX, AXIS_LX};
  localparam logic  JOINT_NEG  [NUM_JOINTS] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
  localparam mode_t JOINT_MODE [NUM_JOINTS] = '{MODE_POS, MODE_POS, MODE_POS,
                                                MODE_ORIENT, MODE_ORIENT, MODE_ORIENT};

  // state
  angle_t     measured_angle [NUM_JOINTS];
  logic       measured_valid [NUM_JOINTS];
  angle_t     limit_lo       [NUM_JOINTS];
  angle_t     limit_hi       [NUM_JOINTS];
  logic       limits_valid   [NUM_JOINTS];
  angle_t     tgt            [NUM_JOINTS];
  logic       armed_once, orient_toggle, custom_toggle;
  logic [1:0] prev_buttons;
  mode_t      prev_mode;

  logic       armed_once_next, orient_toggle_next, custom_toggle_next;
  logic [1:0] prev_buttons_next;
  mode_t      prev_mode_next;

  logic       is_tick, accept, sw_on, load_meas, zero_invalid, en_now;
  mode_t      mode_now;

  angle_t                   base     [NUM_JOINTS];
  logic signed [SUM_W-1:0]  base_ext [NUM_JOINTS];
  logic signed [SUM_W-1:0]  d_ext    [NUM_JOINTS];
  logic signed [SUM_W-1:0]  sum      [NUM_JOINTS];
  logic signed [SUM_W-1:0]  lo       [NUM_JOINTS];
  logic signed [SUM_W-1:0]  hi       [NUM_JOINTS];
  logic signed [SUM_W-1:0]  clip_lo  [NUM_JOINTS];
  logic signed [SUM_W-1:0]  clip_hi  [NUM_JOINTS];
  logic                     jog_on   [NUM_JOINTS];
  angle_t                   tgt_next [NUM_JOINTS];

  assign is_tick    = (mid.item.cmd == CMD_TICK);
  assign mid_ready  = !is_tick || emit_ready;
  assign accept     = mid_valid && mid_ready;
  assign burst_load = accept && is_tick;

  // enable, sub-mode toggles and mode selection for a tick
  always_comb begin
    armed_once_next    = armed_once;
    orient_toggle_next = orient_toggle;
    custom_toggle_next = custom_toggle;
    prev_buttons_next  = prev_buttons;
    prev_mode_next     = prev_mode;
    mode_now           = MODE_NONE;
    en_now             = 1'b0;
    load_meas          = 1'b0;
    zero_invalid       = 1'b0;
    sw_on = (mid.item.switch_pos == SW_MIDDLE) || (mid.item.switch_pos == SW_RIGHT);
    if (!armed_once) begin
      armed_once_next = sw_on;
      load_meas       = 1'b1;
      zero_invalid    = 1'b1;
    end else if (!sw_on) begin
      load_meas      = 1'b1;
      zero_invalid   = 1'b1;
      prev_mode_next = MODE_NONE;
    end else begin
      en_now = 1'b1;
      if (mid.item.button_one && !prev_buttons[0]) orient_toggle_next = !orient_toggle;
      if (mid.item.button_two && !prev_buttons[1]) custom_toggle_next = !custom_toggle;
      if (mid.item.switch_pos == SW_MIDDLE) begin
        mode_now = orient_toggle_next ? MODE_ORIENT : MODE_POS;
      end else begin
        mode_now = custom_toggle_next ? MODE_CUSTOM : MODE_GRIPPER;
      end
      load_meas         = (mode_now != prev_mode) && (mode_now != MODE_GRIPPER);
      prev_buttons_next = {mid.item.button_two, mid.item.button_one};
      prev_mode_next    = mode_now;
    end
  end

  // per joint: reload from measured angle, then jog and clamp
  always_comb begin
    for (int j = 0; j < NUM_JOINTS; j++) begin
      base[j] = tgt[j];
      if (load_meas) begin
        if (measured_valid[j]) begin
          base[j] = measured_angle[j];
        end else if (zero_invalid) begin
          base[j] = '0;
        end
      end
      base_ext[j] = {{(SUM_W - ANGLE_BITS){base[j][ANGLE_BITS-1]}}, base[j]};
      d_ext[j]    = {{(SUM_W - DELTA_W){mid.delta[JOINT_AXIS[j]][DELTA_W-1]}},
                     mid.delta[JOINT_AXIS[j]]};
      sum[j]      = JOINT_NEG[j] ? (base_ext[j] - d_ext[j]) : (base_ext[j] + d_ext[j]);
      if (limits_valid[j]) begin
        lo[j] = {{(SUM_W - ANGLE_BITS){limit_lo[j][ANGLE_BITS-1]}}, limit_lo[j]};
        hi[j] = {{(SUM_W - ANGLE_BITS){limit_hi[j][ANGLE_BITS-1]}}, limit_hi[j]};
      end else begin
        lo[j] = SUM_W'(-CLAMP_PI);
        hi[j] = SUM_W'(CLAMP_PI);
      end
      // crossed limits end at the upper one
      clip_lo[j]  = (sum[j] < lo[j]) ? lo[j] : sum[j];
      clip_hi[j]  = (clip_lo[j] > hi[j]) ? hi[j] : clip_lo[j];
      jog_on[j]   = mid.move[JOINT_AXIS[j]] && (mode_now == JOINT_MODE[j]);
      tgt_next[j] = jog_on[j] ? clip_hi[j][ANGLE_BITS-1:0] : base[j];
    end
  end

  // burst handed to the emitter
  always_comb begin
    for (int j = 0; j < NUM_JOINTS; j++) begin
      burst.targets[j] = tgt_next[j];
    end
    burst.enabled = en_now;
    burst.mode    = mode_now;
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NUM_JOINTS; j++) begin
        measured_angle[j] <= '0;
        measured_valid[j] <= 1'b0;
        limit_lo[j]       <= '0;
        limit_hi[j]       <= '0;
        limits_valid[j]   <= 1'b0;
        tgt[j]            <= '0;
      end
      armed_once    <= 1'b0;
      orient_toggle <= 1'b0;
      custom_toggle <= 1'b0;
      prev_buttons  <= '0;
      prev_mode     <= MODE_NONE;
    end else if (accept) begin
      unique case (mid.item.cmd)
        CMD_TICK: begin
          for (int j = 0; j < NUM_JOINTS; j++) begin
            tgt[j] <= tgt_next[j];
          end
          armed_once    <= armed_once_next;
          orient_toggle <= orient_toggle_next;
          custom_toggle <= custom_toggle_next;
          prev_buttons  <= prev_buttons_next;
          prev_mode     <= prev_mode_next;
        end
        CMD_ANGLE: begin
          if (mid.item.joint_sel < JOINT_W'(NUM_JOINTS)) begin
            measured_angle[mid.item.joint_sel] <= mid.item.value_a;
            measured_valid[mid.item.joint_sel] <= mid.item.value_valid;
          end
        end
        CMD_LIMIT: begin
          if (mid.item.joint_sel < JOINT_W'(NUM_JOINTS)) begin
            limit_lo[mid.item.joint_sel]     <= mid.item.value_a;
            limit_hi[mid.item.joint_sel]     <= mid.item.value_b;
            limits_valid[mid.item.joint_sel] <= mid.item.value_valid;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/jjjc_emit.sv
// jjjc_emit: result register; holds one tick's targets and sends them one joint per cycle while result_stall is low
// depends on jjjc_pkg

module jjjc_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                burst_load,
  input  jjjc_pkg::burst_t    burst,
  output logic                emit_ready,
  output logic                result_valid,
  input  logic                result_stall,
  output jjjc_pkg::out_item_t result
);
  import jjjc_pkg::*;

  localparam logic [JOINT_W-1:0] LAST_JOINT = JOINT_W'(NUM_JOINTS - 1);

  burst_t             held;
  logic [JOINT_W-1:0] idx;
  logic               busy, take, at_last;

  assign result_valid = busy;
  assign take         = busy && !result_stall;
  assign at_last      = (idx == LAST_JOINT);
  assign emit_ready   = !busy || (take && at_last);

  // burst counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (burst_load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (take) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (burst_load) begin
      held <= burst;
    end
  end

  // result payload
  assign result.out_joint    = idx;
  assign result.target_angle = held.targets[idx];
  assign result.enabled      = held.enabled;
  assign result.mode         = held.mode;
  assign result.last_joint   = at_last;

endmodule

// File: rtl/joystick_joint_jog_controller_unit.sv
// Joystick joint jog controller: six joint targets jogged from a hand controller.
// A control tick is registered in the input stage, then waits for the result register,
// which sends one joint a cycle while result_stall is low and takes the next tick as the
// last joint goes; angle and limit updates give no result and are taken one per cycle
// unless stalled behind a waiting tick. Reset (synchronous, rst high) clears all joint
// state and mode state and loads the register defaults; no clearing pass.

module joystick_joint_jog_controller_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [jjjc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [jjjc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [jjjc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  jjjc_pkg::in_item_t              item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output jjjc_pkg::out_item_t             result
);
  import jjjc_pkg::*;

  cfg_t   cfg;
  mid_t   mid;
  logic   mid_valid, mid_ready;
  burst_t burst;
  logic   burst_load, emit_ready;

  // configuration registers
  jjjc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input stage with jog deltas
  jjjc_delta u_delta (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .mid_valid  (mid_valid),
    .mid_ready  (mid_ready),
    .mid        (mid)
  );

  // joint state and mode logic
  jjjc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .mid_valid  (mid_valid),
    .mid_ready  (mid_ready),
    .mid        (mid),
    .emit_ready (emit_ready),
    .burst_load (burst_load),
    .burst      (burst)
  );

  // per-joint result sequencing
  jjjc_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .burst_load   (burst_load),
    .burst        (burst),
    .emit_ready   (emit_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
